// ===== hdl/sva_pkg.sv =====
// Shared types and constants for the sound voice allocator.
`default_nettype none
package sva_pkg;

	localparam int EVENT_W = 3;
	localparam int CHAN_OUT_W = 3;
	localparam int COUNT_OUT_W = 5;
	localparam int TIME_W = 32;
	localparam int POS_W = 32;
	localparam int SOUND_W = 16;
	localparam int GAIN_W = 16;

	typedef enum logic [EVENT_W-1:0] {
		EV_STOPPED  = 3'd0,
		EV_STARTED  = 3'd1,
		EV_STATUS   = 3'd2,
		EV_ACCEPTED = 3'd3,
		EV_DROPPED  = 3'd4
	} sva_event_t;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_CUE  = 1'b1
	} sva_command_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENQ,
		ST_STOP,
		ST_START,
		ST_START_WAIT,
		ST_STATUS
	} sva_state_t;

	// One input transaction as the datapath latches it.
	typedef struct packed {
		logic                     command;
		logic [TIME_W-1:0]        tick_delta;
		logic [TIME_W-1:0]        cue_length;
		logic [SOUND_W-1:0]       cue_sound_id;
		logic [GAIN_W-1:0]        cue_volume;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
	} sva_cue_t;

	// One queued cue.
	typedef struct packed {
		logic [TIME_W-1:0]        len;
		logic [SOUND_W-1:0]       sound;
		logic [GAIN_W-1:0]        gain;
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic signed [POS_W-1:0]  z;
	} sva_entry_t;

	// One result transaction.
	typedef struct packed {
		logic [EVENT_W-1:0]       event_res;
		logic [CHAN_OUT_W-1:0]    channel;
		logic [SOUND_W-1:0]       sound_id;
		logic [GAIN_W-1:0]        volume;
		logic signed [POS_W-1:0]  out_x;
		logic signed [POS_W-1:0]  out_y;
		logic signed [POS_W-1:0]  out_z;
		logic [COUNT_OUT_W-1:0]   queue_count;
		logic                     last;
	} sva_result_t;

	typedef struct packed {
		logic load;
		logic enq;
		logic upd;
		logic stop;
		logic start;
		logic status;
		logic idx_inc;
		logic idx_clr;
	} sva_cmd_t;

	typedef struct packed {
		logic cur_active;
		logic cur_expire;
		logic idx_last;
		logic fifo_empty;
		logic out_free;
	} sva_status_t;

endpackage
`default_nettype wire

// ===== hdl/sva_ifs.sv =====
// Request and result channel interfaces of the sound voice allocator.
`default_nettype none
interface sva_req_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [31:0]        tick_delta;
	logic [31:0]        cue_length;
	logic [15:0]        cue_sound_id;
	logic [15:0]        cue_volume;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source(output valid, command, tick_delta, cue_length, cue_sound_id,
		cue_volume, pos_x, pos_y, pos_z, input ready);
	modport sink(input valid, command, tick_delta, cue_length, cue_sound_id,
		cue_volume, pos_x, pos_y, pos_z, output ready);
endinterface

interface sva_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         event_res;
	logic [2:0]         channel;
	logic [15:0]        sound_id;
	logic [15:0]        volume;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [4:0]         queue_count;
	logic               last;

	modport source(output valid, event_res, channel, sound_id, volume, out_x,
		out_y, out_z, queue_count, last, input ready);
	modport sink(input valid, event_res, channel, sound_id, volume, out_x,
		out_y, out_z, queue_count, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/sva_ctrl.sv =====
// Controller state machine that sequences enqueue and tick processing.
`default_nettype none
module sva_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_command,
	output logic                    in_ready,
	input  wire sva_pkg::sva_status_t stat,
	output sva_pkg::sva_cmd_t       cmd
);
	import sva_pkg::*;

	sva_state_t state_q;
	sva_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.idx_clr = 1'b1;
					state_nxt = (in_command == CMD_CUE) ? ST_ENQ : ST_STOP;
				end
			end
			ST_ENQ: begin
				if (stat.out_free) begin
					cmd.enq = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_STOP: begin
				// Only an expiring channel needs the output register.
				if (!(stat.cur_active && stat.cur_expire) || stat.out_free) begin
					cmd.upd = stat.cur_active;
					cmd.stop = stat.cur_active && stat.cur_expire;
					if (stat.idx_last) begin
						cmd.idx_clr = 1'b1;
						state_nxt = ST_START;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_START: begin
				if (stat.fifo_empty) begin
					state_nxt = ST_STATUS;
				end else if (stat.cur_active) begin
					if (stat.idx_last) begin
						state_nxt = ST_STATUS;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end else if (stat.out_free) begin
					cmd.start = 1'b1;
					if (stat.idx_last) begin
						state_nxt = ST_STATUS;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt = ST_START_WAIT;
					end
				end
			end
			ST_START_WAIT: begin
				// The queue head read is registered, so this state lets it follow the pop.
				state_nxt = ST_START;
			end
			ST_STATUS: begin
				if (stat.out_free) begin
					cmd.status = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/sva_datapath.sv =====
// Channel state, cue queue memory and result register of the voice allocator.
`default_nettype none
module sva_datapath #(
	parameter int CHANNELS = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sva_pkg::sva_cue_t     cue,
	input  wire sva_pkg::sva_cmd_t     cmd,
	output sva_pkg::sva_status_t       stat,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output sva_pkg::sva_result_t       result
);
	import sva_pkg::*;

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	sva_cue_t               cue_q;
	logic [IW-1:0]          idx_q;
	logic [CHANNELS-1:0]    active_q;
	logic [TIME_W-1:0]      elapsed_q [CHANNELS];
	logic [TIME_W-1:0]      len_q [CHANNELS];
	sva_entry_t             fifo_mem [QUEUE_DEPTH];
	sva_entry_t             rd_q;
	logic [QW-1:0]          head_q;
	logic [QW-1:0]          tail_q;
	logic [CW-1:0]          count_q;
	logic                   out_valid_q;
	sva_result_t            out_q;

	logic [TIME_W:0]        sum;
	logic [TIME_W-1:0]      sat;
	logic                   full;
	logic                   push;
	logic [CW-1:0]          count_nxt;
	logic [31:0]            count_ext;
	logic [31:0]            idx_ext;
	logic                   emit;
	sva_result_t            res_nxt;

	// Saturating elapsed-time update of the channel under the walk index.
	assign sum = {1'b0, elapsed_q[idx_q]} + {1'b0, cue_q.tick_delta};
	assign sat = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign push = cmd.enq && !full;

	always_comb begin
		count_nxt = count_q;
		if (push) begin
			count_nxt = count_q + 1'b1;
		end else if (cmd.start) begin
			count_nxt = count_q - 1'b1;
		end
	end

	assign count_ext = 32'(count_nxt);
	assign idx_ext = 32'(idx_q);

	assign stat.cur_active = active_q[idx_q];
	assign stat.cur_expire = (sat > len_q[idx_q]);
	assign stat.idx_last = (idx_q == IW'(CHANNELS - 1));
	assign stat.fifo_empty = (count_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	assign emit = cmd.enq || cmd.stop || cmd.start || cmd.status;

	always_comb begin
		res_nxt = '0;
		res_nxt.queue_count = count_ext[COUNT_OUT_W-1:0];
		if (cmd.enq) begin
			res_nxt.event_res = full ? EV_DROPPED : EV_ACCEPTED;
			res_nxt.last = 1'b1;
		end else if (cmd.stop) begin
			res_nxt.event_res = EV_STOPPED;
			res_nxt.channel = idx_ext[CHAN_OUT_W-1:0];
		end else if (cmd.start) begin
			res_nxt.event_res = EV_STARTED;
			res_nxt.channel = idx_ext[CHAN_OUT_W-1:0];
			res_nxt.sound_id = rd_q.sound;
			res_nxt.volume = rd_q.gain;
			res_nxt.out_x = rd_q.x;
			res_nxt.out_y = rd_q.y;
			res_nxt.out_z = rd_q.z;
		end else begin
			res_nxt.event_res = EV_STATUS;
			res_nxt.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			active_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.stop) begin
				active_q[idx_q] <= 1'b0;
			end else if (cmd.start) begin
				active_q[idx_q] <= 1'b1;
			end
			if (push) begin
				tail_q <= (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (cmd.start) begin
				head_q <= (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			count_q <= count_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cue_q <= cue;
		end
		if (cmd.upd) begin
			elapsed_q[idx_q] <= sat;
		end else if (cmd.start) begin
			elapsed_q[idx_q] <= '0;
		end
		if (cmd.start) begin
			len_q[idx_q] <= rd_q.len;
		end
		if (emit) begin
			out_q <= res_nxt;
		end
	end

	// Cue queue memory: one write port at the tail, one registered read at the head.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[tail_q] <= '{len: cue_q.cue_length, sound: cue_q.cue_sound_id,
				gain: cue_q.cue_volume, x: cue_q.pos_x, y: cue_q.pos_y, z: cue_q.pos_z};
		end
		rd_q <= fifo_mem[head_q];
	end

	assign out_valid = out_valid_q;
	assign result = out_q;

endmodule
`default_nettype wire

// ===== hdl/sound_voice_allocator_unit.sv =====
// Top level of the sound voice allocator: controller, datapath and channel wiring.
//
// A cue request transaction is queued (or dropped when the queue is full), and
// its single result is loaded into the output register from the enqueue state.
// A tick transaction walks the channels once to advance elapsed time and stop
// expired voices, one channel per cycle unless the output register stalls it,
// then walks them again to start queued cues; a voice started on any channel
// but the last is followed by a wait state, because the queue memory read at
// the head is registered. The start walk ends at the last channel or on the
// first visit that finds the queue empty, and the status state then loads the
// status result. Only one transaction is in work at a time; a waiting result
// in the output register stalls the walk whenever a new result is due, and the
// next request is taken in the cycle after the last result of the current one
// has been loaded into that register.
`default_nettype none
module sound_voice_allocator_unit #(
	parameter int CHANNELS = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sva_req_if.sink    req,
	sva_res_if.source  res
);
	import sva_pkg::*;

	sva_cmd_t    cmd;
	sva_status_t stat;
	sva_cue_t    cue;
	sva_result_t result;
	logic        out_valid;
	logic        in_ready;

	assign cue = '{command: req.command, tick_delta: req.tick_delta,
		cue_length: req.cue_length, cue_sound_id: req.cue_sound_id,
		cue_volume: req.cue_volume, pos_x: req.pos_x, pos_y: req.pos_y,
		pos_z: req.pos_z};

	sva_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_command (req.command),
		.in_ready   (in_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	sva_datapath #(
		.CHANNELS    (CHANNELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cue       (cue),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.result    (result)
	);

	assign req.ready = in_ready;
	assign res.valid = out_valid;
	assign res.event_res = result.event_res;
	assign res.channel = result.channel;
	assign res.sound_id = result.sound_id;
	assign res.volume = result.volume;
	assign res.out_x = result.out_x;
	assign res.out_y = result.out_y;
	assign res.out_z = result.out_z;
	assign res.queue_count = result.queue_count;
	assign res.last = result.last;

endmodule
`default_nettype wire

// ===== tb/sound_voice_allocator_unit_tb.sv =====
// Self-checking testbench for the sound voice allocator: directed table, then random traffic.
module sound_voice_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sva_pkg::*;

	localparam int CHANNELS = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 69;

	typedef struct {
		sva_cue_t    item;
		bit          fixed;
		sva_result_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sva_req_if req_ch();
	sva_res_if res_ch();

	sound_voice_allocator_unit #(
		.CHANNELS(CHANNELS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the allocator state.
	logic             voice_on[CHANNELS];
	logic [31:0]      voice_elapsed[CHANNELS];
	logic [31:0]      voice_len[CHANNELS];
	logic [15:0]      voice_sound[CHANNELS];
	logic [15:0]      voice_gain[CHANNELS];
	sva_entry_t       cue_store[QUEUE_DEPTH];
	int               queue_head;
	int               queue_fill;

	sva_result_t      pending_events[$];
	stim_row_t        directed_rows[$];
	bit               row_fixed;
	sva_result_t      row_result;
	int               errors;

	initial begin
		for (int n = 0; n < CHANNELS; n++) begin
			voice_on[n] = 1'b0;
			voice_elapsed[n] = '0;
			voice_len[n] = 32'h0001_0000;
			voice_sound[n] = '0;
			voice_gain[n] = '0;
		end
		queue_head = 0;
		queue_fill = 0;
		errors = 0;
		row_fixed = 1'b0;
		row_result = '0;
	end

	// Works out the events that one accepted transaction causes.
	task automatic plan_events(input sva_cue_t item);
		sva_result_t r;
		sva_entry_t entry;
		logic [32:0] sum;
		int n;
		if (item.command == CMD_CUE) begin
			r = '0;
			if (queue_fill >= QUEUE_DEPTH) begin
				r.event_res = EV_DROPPED;
			end else begin
				entry.len = item.cue_length;
				entry.sound = item.cue_sound_id;
				entry.gain = item.cue_volume;
				entry.x = item.pos_x;
				entry.y = item.pos_y;
				entry.z = item.pos_z;
				cue_store[(queue_head + queue_fill) % QUEUE_DEPTH] = entry;
				queue_fill++;
				r.event_res = EV_ACCEPTED;
			end
			r.queue_count = queue_fill[4:0];
			r.last = 1'b1;
			pending_events.push_back(r);
		end else begin
			for (n = 0; n < CHANNELS; n++) begin
				if (voice_on[n]) begin
					sum = {1'b0, voice_elapsed[n]} + {1'b0, item.tick_delta};
					voice_elapsed[n] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (voice_elapsed[n] > voice_len[n]) begin
						voice_on[n] = 1'b0;
						r = '0;
						r.event_res = EV_STOPPED;
						r.channel = n[2:0];
						r.queue_count = queue_fill[4:0];
						pending_events.push_back(r);
					end
				end
			end
			// A voice stopped above may take a new cue in the same tick.
			for (n = 0; n < CHANNELS && queue_fill > 0; n++) begin
				if (!voice_on[n]) begin
					entry = cue_store[queue_head];
					voice_on[n] = 1'b1;
					voice_elapsed[n] = '0;
					voice_len[n] = entry.len;
					voice_sound[n] = entry.sound;
					voice_gain[n] = entry.gain;
					queue_head = (queue_head + 1) % QUEUE_DEPTH;
					queue_fill--;
					r = '0;
					r.event_res = EV_STARTED;
					r.channel = n[2:0];
					r.sound_id = entry.sound;
					r.volume = entry.gain;
					r.out_x = entry.x;
					r.out_y = entry.y;
					r.out_z = entry.z;
					r.queue_count = queue_fill[4:0];
					pending_events.push_back(r);
				end
			end
			r = '0;
			r.event_res = EV_STATUS;
			r.queue_count = queue_fill[4:0];
			r.last = 1'b1;
			pending_events.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		sva_cue_t taken;
		sva_result_t want;
		int mark;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				taken.command = req_ch.command;
				taken.tick_delta = req_ch.tick_delta;
				taken.cue_length = req_ch.cue_length;
				taken.cue_sound_id = req_ch.cue_sound_id;
				taken.cue_volume = req_ch.cue_volume;
				taken.pos_x = req_ch.pos_x;
				taken.pos_y = req_ch.pos_y;
				taken.pos_z = req_ch.pos_z;
				mark = pending_events.size();
				plan_events(taken);
				// Rows with a typed answer replace what the predictor worked out.
				if (row_fixed) begin
					while (pending_events.size() > mark)
						void'(pending_events.pop_back());
					pending_events.push_back(row_result);
				end
			end
			if (res_ch.valid && res_ch.ready) begin
				if (pending_events.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result, event %0d channel %0d", $time,
							res_ch.event_res, res_ch.channel);
				end else begin
					want = pending_events.pop_front();
					check_field("event_res", want.event_res, res_ch.event_res);
					check_field("channel", want.channel, res_ch.channel);
					check_field("sound_id", want.sound_id, res_ch.sound_id);
					check_field("volume", want.volume, res_ch.volume);
					check_field("out_x", want.out_x, res_ch.out_x);
					check_field("out_y", want.out_y, res_ch.out_y);
					check_field("out_z", want.out_z, res_ch.out_z);
					check_field("queue_count", want.queue_count, res_ch.queue_count);
					check_field("last", want.last, res_ch.last);
				end
			end
		end
	end

	function automatic int idle_gap(input bit calm);
		return calm ? 0 : int'($urandom_range(7));
	endfunction

	function automatic stim_row_t tick_row(input logic [31:0] delta);
		stim_row_t row;
		row.item = '0;
		row.item.command = CMD_TICK;
		row.item.tick_delta = delta;
		row.fixed = 1'b0;
		row.result = '0;
		return row;
	endfunction

	function automatic stim_row_t cue_row(input logic [31:0] len, input logic [15:0] id,
		input logic [15:0] vol, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z);
		stim_row_t row;
		row.item = '0;
		row.item.command = CMD_CUE;
		row.item.cue_length = len;
		row.item.cue_sound_id = id;
		row.item.cue_volume = vol;
		row.item.pos_x = x;
		row.item.pos_y = y;
		row.item.pos_z = z;
		row.fixed = 1'b0;
		row.result = '0;
		return row;
	endfunction

	function automatic stim_row_t fixed_result(input stim_row_t row, input sva_event_t ev,
		input int count);
		row.fixed = 1'b1;
		row.result = '0;
		row.result.event_res = ev;
		row.result.queue_count = count[4:0];
		row.result.last = 1'b1;
		return row;
	endfunction

	function automatic sva_cue_t random_cue(input int cue_pct);
		sva_cue_t item;
		item.command = ($urandom_range(99) < cue_pct) ? CMD_CUE : CMD_TICK;
		case ($urandom_range(9))
			0, 1: item.tick_delta = $urandom;
			2: item.tick_delta = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
			default: item.tick_delta = $urandom_range(32'h1_8000);
		endcase
		// Mostly short cues so that voices keep turning over.
		case ($urandom_range(9))
			0, 1: item.cue_length = $urandom;
			2: item.cue_length = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFE;
			default: item.cue_length = $urandom_range(32'h3_0000);
		endcase
		item.cue_sound_id = $urandom;
		item.cue_volume = $urandom;
		item.pos_x = $urandom;
		item.pos_y = $urandom;
		item.pos_z = $urandom;
		return item;
	endfunction

	task automatic send_item(input sva_cue_t item, input int gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= item.command;
		req_ch.tick_delta <= item.tick_delta;
		req_ch.cue_length <= item.cue_length;
		req_ch.cue_sound_id <= item.cue_sound_id;
		req_ch.cue_volume <= item.cue_volume;
		req_ch.pos_x <= item.pos_x;
		req_ch.pos_y <= item.pos_y;
		req_ch.pos_z <= item.pos_z;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Result side: a fresh random stall before every result, with calm stretches.
	initial begin : result_sink
		bit calm;
		int gap;
		calm = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(39) == 0)
				calm = !calm;
			gap = idle_gap(calm);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int phase_pct[RANDOM_PHASES];
		bit calm;
		phase_pct = '{35, 85, 25, 60, 90, 40};
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_TICK;
		req_ch.tick_delta = '0;
		req_ch.cue_length = '0;
		req_ch.cue_sound_id = '0;
		req_ch.cue_volume = '0;
		req_ch.pos_x = '0;
		req_ch.pos_y = '0;
		req_ch.pos_z = '0;

		// Empty allocator, then a full queue of cues and one dropped.
		directed_rows.push_back(fixed_result(tick_row(32'h0), EV_STATUS, 0));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'hFFFF, 16'hFFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), EV_ACCEPTED, 1));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'h0000, 16'h0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000), EV_ACCEPTED, 2));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'h1234, 16'h0100,
			32'h0001_0000, 32'hFFFF_0000, 32'h0), EV_ACCEPTED, 3));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'h5555, 16'hAAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F), EV_ACCEPTED, 4));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'hAAAA, 16'h5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0), EV_ACCEPTED, 5));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'h0006, 16'h0080,
			32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001), EV_ACCEPTED, 6));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'h0007, 16'h0200,
			32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_0000), EV_ACCEPTED, 7));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'h8000, 16'h0001,
			32'h1234_5678, 32'h9ABC_DEF0, 32'h0BAD_F00D), EV_ACCEPTED, 8));
		directed_rows.push_back(fixed_result(cue_row(32'h0000_8000, 16'h0009, 16'h0100,
			32'h0001_0000, 32'h0002_0000, 32'h0003_0000), EV_ACCEPTED, 9));
		directed_rows.push_back(fixed_result(cue_row(32'h0001_0000, 16'h000A, 16'h0100,
			32'h0, 32'h0, 32'h0), EV_ACCEPTED, 10));
		directed_rows.push_back(fixed_result(cue_row(32'h0002_0000, 16'h000B, 16'h0180,
			32'hFFFE_0000, 32'h0, 32'h0001_8000), EV_ACCEPTED, 11));
		directed_rows.push_back(fixed_result(cue_row(32'h0000_0001, 16'h000C, 16'h0040,
			32'h0, 32'h7FFF_FFFF, 32'h0), EV_ACCEPTED, 12));
		directed_rows.push_back(fixed_result(cue_row(32'h0000_FFFF, 16'h000D, 16'h0100,
			32'h8000_0000, 32'h0, 32'h0), EV_ACCEPTED, 13));
		directed_rows.push_back(fixed_result(cue_row(32'h7FFF_FFFF, 16'h000E, 16'h0100,
			32'h0, 32'h0, 32'h8000_0000), EV_ACCEPTED, 14));
		directed_rows.push_back(fixed_result(cue_row(32'hFFFF_FFFE, 16'h000F, 16'hFF00,
			32'h0, 32'h0, 32'h0), EV_ACCEPTED, 15));
		// This cue never expires; it lands on the highest channel and stays there.
		directed_rows.push_back(fixed_result(cue_row(32'hFFFF_FFFF, 16'hFFFE, 16'h00FF,
			32'h0000_0010, 32'h0000_0020, 32'h0000_0030), EV_ACCEPTED, 16));
		directed_rows.push_back(fixed_result(cue_row(32'h0, 16'hDEAD, 16'hBEEF,
			32'h1, 32'h2, 32'h3), EV_DROPPED, 16));
		// Fill every channel, then stop and restart all of them in one tick.
		directed_rows.push_back(tick_row(32'h0));
		directed_rows.push_back(tick_row(32'h1));
		directed_rows.push_back(tick_row(32'h0001_0000));
		// Elapsed time saturates instead of wrapping.
		directed_rows.push_back(tick_row(32'hFFFF_FFFF));
		directed_rows.push_back(cue_row(32'h0002_0000, 16'hABCD, 16'h0100,
			32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF));
		directed_rows.push_back(tick_row(32'h0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			row_fixed = directed_rows[i].fixed;
			row_result = directed_rows[i].result;
			send_item(directed_rows[i].item, idle_gap(1'b0));
		end
		row_fixed = 1'b0;

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			calm = (phase == 3);
			if (phase == 2) begin
				// Let the allocator drain completely before going on.
				req_ch.valid <= 1'b0;
				while (pending_events.size() != 0)
					@(negedge clk);
			end
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_item(random_cue(phase_pct[phase]), idle_gap(calm));
		end
		req_ch.valid <= 1'b0;

		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_events.size() == 0)
			$display("sound_voice_allocator_unit_tb: clean");
		else
			$display("sound_voice_allocator_unit_tb: errors");
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("sound_voice_allocator_unit_tb: errors");
		$finish;
	end

endmodule
